// ===== hdl/hit_pair_delta_phi_window_core_defines.svh =====
// Assertion macros used by the top RTL file of the hit pair azimuth window block.
`ifndef HIT_PAIR_DELTA_PHI_WINDOW_CORE_DEFINES_SVH
`define HIT_PAIR_DELTA_PHI_WINDOW_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define HPDP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpdp: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define HPDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpdp: next-cycle check failed");

`endif

// ===== hdl/hpdp_pkg.sv =====
package hpdp_pkg;

    localparam int COORD_BITS      = 24;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STAGES   = 20;

    localparam int HITS_BITS    = 8;
    localparam int ANGLE_BITS   = 16;
    localparam int R2_BITS      = 21;
    localparam int CFG_BITS     = 21;
    localparam int CFG_IDX_BITS = 2;
    localparam int TURN_BITS    = 32;

    // Internal CORDIC precision: coordinates are scaled up to PREC_BITS and
    // the datapath keeps headroom for the CORDIC gain.
    localparam int PREC_BITS   = 48;
    localparam int SCALE_SHIFT = PREC_BITS - COORD_BITS;
    localparam int CORDIC_W    = PREC_BITS + 4;
    localparam int CORDIC_EXT  = CORDIC_W - COORD_BITS - 1 - SCALE_SHIFT;

    // A coordinate at or above 2^SMALL_BITS squares past any threshold value.
    localparam int SMALL_BITS = (R2_BITS + 1) / 2;
    localparam int SQ_BITS    = 2 * SMALL_BITS + 1;

    // Turn to degree conversion: angle = (mag * DEG_SCALE + half) >> 32.
    localparam int DEG_SCALE = 360 * (1 << ANGLE_FRAC_BITS);
    localparam int DEG_BITS  = $clog2(DEG_SCALE + 1);
    localparam int PROD_W    = (TURN_BITS + DEG_BITS >= TURN_BITS + ANGLE_BITS) ?
                               TURN_BITS + DEG_BITS : TURN_BITS + ANGLE_BITS;
    localparam int ANG_W     = PROD_W - TURN_BITS;

    localparam logic [TURN_BITS-1:0] HALF_TURN = {1'b1, {(TURN_BITS-1){1'b0}}};

    localparam logic [ANGLE_BITS-1:0] ANGLE_MIN_RESET = ANGLE_BITS'(0);
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX_RESET = ANGLE_BITS'(46080);
    localparam logic [R2_BITS-1:0]    NEAR_R2_RESET   = R2_BITS'(105);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ANGLE_MIN = 2'd0,
        REG_ANGLE_MAX = 2'd1,
        REG_NEAR_R2   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VERDICT_PASS    = 2'd0,
        VERDICT_REJECT  = 2'd1,
        VERDICT_BAD_LEN = 2'd2
    } t_verdict;

    typedef struct packed {
        logic bad;
        logic near;
    } t_side;

    // One hit after folding into the right half plane.
    typedef struct packed {
        logic signed [COORD_BITS:0] x;
        logic signed [COORD_BITS:0] y;
        logic                       half;
        logic                       zero;
    } t_hit;

    // atan(2^-i) in units of 2^-32 turn, truncated.
    function automatic logic [TURN_BITS-1:0] atan_turn(input int i);
        logic [TURN_BITS-1:0] v;
        unique case (i)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051D;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2E;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2F9;
            15:      v = 32'h0000_517C;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A2F;
            19:      v = 32'h0000_0517;
            20:      v = 32'h0000_028B;
            21:      v = 32'h0000_0145;
            22:      v = 32'h0000_00A2;
            23:      v = 32'h0000_0051;
            24:      v = 32'h0000_0028;
            25:      v = 32'h0000_0014;
            26:      v = 32'h0000_000A;
            27:      v = 32'h0000_0005;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/hpdp_prep.sv =====
module hpdp_prep (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic signed [hpdp_pkg::COORD_BITS-1:0]   i_parent_x,
    input  logic signed [hpdp_pkg::COORD_BITS-1:0]   i_parent_y,
    input  logic signed [hpdp_pkg::COORD_BITS-1:0]   i_child_x,
    input  logic signed [hpdp_pkg::COORD_BITS-1:0]   i_child_y,
    input  logic        [hpdp_pkg::HITS_BITS-1:0]    i_parent_hits,
    input  logic        [hpdp_pkg::HITS_BITS-1:0]    i_child_hits,
    input  logic        [hpdp_pkg::R2_BITS-1:0]      i_near_r2,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output hpdp_pkg::t_side                          o_side,
    output hpdp_pkg::t_hit                           o_hit [2]
);
    import hpdp_pkg::*;

    // Stage 1: hit count check, magnitudes, fold into right half plane.
    logic                      r1_v;
    t_side                     r1_side;
    t_hit                      r1_hit   [2];
    logic                      r1_small [2];
    logic [SMALL_BITS-1:0]     r1_lx    [2];
    logic [SMALL_BITS-1:0]     r1_ly    [2];
    // Stage 2: squares of the low magnitude bits.
    logic                      r2_v;
    t_side                     r2_side;
    t_hit                      r2_hit   [2];
    logic                      r2_small [2];
    logic [2*SMALL_BITS-1:0]   r2_sqx   [2];
    logic [2*SMALL_BITS-1:0]   r2_sqy   [2];
    // Stage 3: near-origin decision.
    logic                      r3_v;
    t_side                     r3_side;
    t_hit                      r3_hit   [2];

    t_side                     n1_side;
    t_hit                      n1_hit   [2];
    logic                      n1_small [2];
    logic [SMALL_BITS-1:0]     n1_lx    [2];
    logic [SMALL_BITS-1:0]     n1_ly    [2];
    logic [2*SMALL_BITS-1:0]   n2_sqx   [2];
    logic [2*SMALL_BITS-1:0]   n2_sqy   [2];
    t_side                     n3_side;

    logic signed [COORD_BITS-1:0] w_x [2];
    logic signed [COORD_BITS-1:0] w_y [2];
    logic rdy1, rdy2, rdy3;

    assign w_x[0] = i_parent_x;
    assign w_y[0] = i_parent_y;
    assign w_x[1] = i_child_x;
    assign w_y[1] = i_child_y;

    always_comb begin
        logic [COORD_BITS-1:0]   ax;
        logic [COORD_BITS-1:0]   ay;
        logic signed [COORD_BITS:0] xe;
        logic signed [COORD_BITS:0] ye;
        n1_side.bad  = (i_parent_hits != HITS_BITS'(1)) || (i_child_hits != HITS_BITS'(1));
        n1_side.near = 1'b0;
        for (int h = 0; h < 2; h++) begin
            ax = w_x[h][COORD_BITS-1] ? -w_x[h] : w_x[h];
            ay = w_y[h][COORD_BITS-1] ? -w_y[h] : w_y[h];
            n1_small[h] = (ax[COORD_BITS-1:SMALL_BITS] == '0) &&
                          (ay[COORD_BITS-1:SMALL_BITS] == '0);
            n1_lx[h] = ax[SMALL_BITS-1:0];
            n1_ly[h] = ay[SMALL_BITS-1:0];
            xe = {w_x[h][COORD_BITS-1], w_x[h]};
            ye = {w_y[h][COORD_BITS-1], w_y[h]};
            // A hit in the left half plane is turned by half a turn first.
            n1_hit[h].x    = w_x[h][COORD_BITS-1] ? -xe : xe;
            n1_hit[h].y    = w_x[h][COORD_BITS-1] ? -ye : ye;
            n1_hit[h].half = w_x[h][COORD_BITS-1];
            n1_hit[h].zero = (w_x[h] == '0) && (w_y[h] == '0);
        end
    end

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            n2_sqx[h] = (2*SMALL_BITS)'(r1_lx[h]) * (2*SMALL_BITS)'(r1_lx[h]);
            n2_sqy[h] = (2*SMALL_BITS)'(r1_ly[h]) * (2*SMALL_BITS)'(r1_ly[h]);
        end
    end

    always_comb begin
        logic [SQ_BITS-1:0] sum;
        logic               near [2];
        for (int h = 0; h < 2; h++) begin
            sum     = SQ_BITS'(r2_sqx[h]) + SQ_BITS'(r2_sqy[h]);
            near[h] = r2_small[h] && (sum < SQ_BITS'(i_near_r2));
        end
        n3_side.bad  = r2_side.bad;
        n3_side.near = near[0] || near[1];
    end

    assign rdy3    = !r3_v || i_ready;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_side <= n1_side;
            for (int h = 0; h < 2; h++) begin
                r1_hit[h]   <= n1_hit[h];
                r1_small[h] <= n1_small[h];
                r1_lx[h]    <= n1_lx[h];
                r1_ly[h]    <= n1_ly[h];
            end
        end
        if (rdy2) begin
            r2_side <= r1_side;
            for (int h = 0; h < 2; h++) begin
                r2_hit[h]   <= r1_hit[h];
                r2_small[h] <= r1_small[h];
                r2_sqx[h]   <= n2_sqx[h];
                r2_sqy[h]   <= n2_sqy[h];
            end
        end
        if (rdy3) begin
            r3_side <= n3_side;
            for (int h = 0; h < 2; h++) begin
                r3_hit[h] <= r2_hit[h];
            end
        end
    end

    assign o_valid  = r3_v;
    assign o_side   = r3_side;
    assign o_hit[0] = r3_hit[0];
    assign o_hit[1] = r3_hit[1];

endmodule

// ===== hdl/hpdp_cordic.sv =====
module hpdp_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  hpdp_pkg::t_side                     i_side,
    input  hpdp_pkg::t_hit                      i_hit [2],
    output logic                                o_valid,
    input  logic                                i_ready,
    output hpdp_pkg::t_side                     o_side,
    output logic [hpdp_pkg::TURN_BITS-1:0]      o_z [2]
);
    import hpdp_pkg::*;

    // One vectoring iteration per register stage, both hits side by side.
    logic                        r_v    [CORDIC_STAGES];
    t_side                       r_side [CORDIC_STAGES];
    logic [1:0]                  r_zero [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  r_x    [2][CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  r_y    [2][CORDIC_STAGES];
    logic [TURN_BITS-1:0]        r_z    [2][CORDIC_STAGES];

    logic                        w_v    [CORDIC_STAGES];
    t_side                       w_side [CORDIC_STAGES];
    logic [1:0]                  w_zero [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  w_x    [2][CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  w_y    [2][CORDIC_STAGES];
    logic [TURN_BITS-1:0]        w_z    [2][CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  n_x    [2][CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  n_y    [2][CORDIC_STAGES];
    logic [TURN_BITS-1:0]        n_z    [2][CORDIC_STAGES];
    logic [CORDIC_STAGES:0]      w_rdy;

    always_comb begin
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        w_v[0]    = i_valid;
        w_side[0] = i_side;
        w_zero[0] = {i_hit[1].zero, i_hit[0].zero};
        for (int h = 0; h < 2; h++) begin
            w_x[h][0] = {{CORDIC_EXT{i_hit[h].x[COORD_BITS]}}, i_hit[h].x,
                         {SCALE_SHIFT{1'b0}}};
            w_y[h][0] = {{CORDIC_EXT{i_hit[h].y[COORD_BITS]}}, i_hit[h].y,
                         {SCALE_SHIFT{1'b0}}};
            w_z[h][0] = i_hit[h].half ? HALF_TURN : '0;
        end
        for (int i = 1; i < CORDIC_STAGES; i++) begin
            w_v[i]    = r_v[i-1];
            w_side[i] = r_side[i-1];
            w_zero[i] = r_zero[i-1];
            for (int h = 0; h < 2; h++) begin
                w_x[h][i] = r_x[h][i-1];
                w_y[h][i] = r_y[h][i-1];
                w_z[h][i] = r_z[h][i-1];
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            for (int h = 0; h < 2; h++) begin
                dx = w_y[h][i] >>> i;
                dy = w_x[h][i] >>> i;
                if (!w_y[h][i][CORDIC_W-1]) begin
                    n_x[h][i] = w_x[h][i] + dx;
                    n_y[h][i] = w_y[h][i] - dy;
                    n_z[h][i] = w_z[h][i] + atan_turn(i);
                end else begin
                    n_x[h][i] = w_x[h][i] - dx;
                    n_y[h][i] = w_y[h][i] + dy;
                    n_z[h][i] = w_z[h][i] - atan_turn(i);
                end
            end
        end
    end

    // A stage takes a new beat when it is empty or its successor moves on.
    always_comb begin
        w_rdy[CORDIC_STAGES] = i_ready;
        for (int i = CORDIC_STAGES - 1; i >= 0; i--) begin
            w_rdy[i] = !r_v[i] || w_rdy[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                if (w_rdy[i]) r_v[i] <= w_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (w_rdy[i]) begin
                r_side[i] <= w_side[i];
                r_zero[i] <= w_zero[i];
                for (int h = 0; h < 2; h++) begin
                    r_x[h][i] <= n_x[h][i];
                    r_y[h][i] <= n_y[h][i];
                    r_z[h][i] <= n_z[h][i];
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[CORDIC_STAGES-1];
    assign o_side  = r_side[CORDIC_STAGES-1];
    // A hit at exactly the origin has azimuth zero.
    assign o_z[0]  = r_zero[CORDIC_STAGES-1][0] ? '0 : r_z[0][CORDIC_STAGES-1];
    assign o_z[1]  = r_zero[CORDIC_STAGES-1][1] ? '0 : r_z[1][CORDIC_STAGES-1];

endmodule

// ===== hdl/hpdp_finish.sv =====
module hpdp_finish (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  hpdp_pkg::t_side                     i_side,
    input  logic [hpdp_pkg::TURN_BITS-1:0]      i_z [2],
    input  logic [hpdp_pkg::ANGLE_BITS-1:0]     i_angle_min,
    input  logic [hpdp_pkg::ANGLE_BITS-1:0]     i_angle_max,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_verdict,
    output logic [hpdp_pkg::ANGLE_BITS-1:0]     o_angle_diff
);
    import hpdp_pkg::*;

    logic                   r1_v;
    t_side                  r1_side;
    logic [TURN_BITS-1:0]   r1_mag;
    logic                   r2_v;
    t_side                  r2_side;
    logic [PROD_W-1:0]      r2_prod;
    logic                   r3_v;
    t_verdict               r_verdict;
    logic [ANGLE_BITS-1:0]  r_angle;

    logic [TURN_BITS-1:0]   n1_mag;
    logic [PROD_W-1:0]      n2_prod;
    t_verdict               n_verdict;
    logic [ANGLE_BITS-1:0]  n_angle;
    logic rdy1, rdy2, rdy3;

    // The difference wraps modulo one turn; half a turn keeps its magnitude.
    always_comb begin
        logic [TURN_BITS-1:0] d;
        d      = i_z[0] - i_z[1];
        n1_mag = d[TURN_BITS-1] ? -d : d;
    end

    assign n2_prod = PROD_W'(r1_mag) * PROD_W'(DEG_SCALE);

    always_comb begin
        logic [PROD_W-1:0] rounded;
        logic [ANG_W-1:0]  ang;
        rounded = r2_prod + PROD_W'(HALF_TURN);
        ang     = r2_side.near ? '0 : rounded[PROD_W-1:TURN_BITS];
        priority if (r2_side.bad) begin
            n_verdict = VERDICT_BAD_LEN;
            n_angle   = '0;
        end else if ((ang > ANG_W'(i_angle_max)) || (ang < ANG_W'(i_angle_min))) begin
            n_verdict = VERDICT_REJECT;
            n_angle   = ang[ANGLE_BITS-1:0];
        end else begin
            n_verdict = VERDICT_PASS;
            n_angle   = ang[ANGLE_BITS-1:0];
        end
    end

    assign rdy3    = !r3_v || !i_stall;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_side <= i_side;
            r1_mag  <= n1_mag;
        end
        if (rdy2) begin
            r2_side <= r1_side;
            r2_prod <= n2_prod;
        end
        if (rdy3) begin
            r_verdict <= n_verdict;
            r_angle   <= n_angle;
        end
    end

    assign o_valid      = r3_v;
    assign o_verdict    = r_verdict;
    assign o_angle_diff = r_angle;

endmodule

// ===== hdl/hit_pair_delta_phi_window_core.sv =====
// Azimuth-difference window test on a pair of tracker hits.
// Input channel: one beat carries the parent and child (x, y) points in
// 1/1024 mm and the hit count of each segment; it is taken at a rising edge
// with i_valid high and o_stall low. Output channel: one beat carries the
// verdict and the absolute azimuth difference in 1/256 degree; it is taken
// at a rising edge with o_valid high and i_stall low.
// Every input beat gives exactly one output beat, in order.
// The pipeline has 26 register stages: three check hit counts and the
// near-origin radius, twenty run the CORDIC iterations of both hits in
// parallel, three form the difference, convert it to degrees and apply
// the window. One beat is accepted every cycle while o_stall is low.
// Each stage holds its own valid bit, so an empty stage keeps filling while
// the output waits; o_stall rises only when every stage holds a beat and
// i_stall is high. A stall loses and repeats nothing.
// Synchronous reset empties the pipeline and loads the window bounds
// 0 and 46080 and the squared-radius threshold 105. The configuration port
// writes one register per cycle. The user must write it only while the
// block is idle; the block itself does not enforce this.
`include "hit_pair_delta_phi_window_core_defines.svh"

module hit_pair_delta_phi_window_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [hpdp_pkg::COORD_BITS-1:0]   i_parent_x,
    input  logic signed [hpdp_pkg::COORD_BITS-1:0]   i_parent_y,
    input  logic signed [hpdp_pkg::COORD_BITS-1:0]   i_child_x,
    input  logic signed [hpdp_pkg::COORD_BITS-1:0]   i_child_y,
    input  logic        [hpdp_pkg::HITS_BITS-1:0]    i_parent_hits,
    input  logic        [hpdp_pkg::HITS_BITS-1:0]    i_child_hits,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic        [1:0]                        o_verdict,
    output logic        [hpdp_pkg::ANGLE_BITS-1:0]   o_angle_diff,
    input  logic                                     i_cfg_we,
    input  logic        [hpdp_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic        [hpdp_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import hpdp_pkg::*;

    logic [ANGLE_BITS-1:0] r_angle_min;
    logic [ANGLE_BITS-1:0] r_angle_max;
    logic [R2_BITS-1:0]    r_near_r2;

    logic                  w_prep_ready;
    logic                  w_prep_valid;
    t_side                 w_prep_side;
    t_hit                  w_prep_hit [2];
    logic                  w_cordic_ready;
    logic                  w_cordic_valid;
    t_side                 w_cordic_side;
    logic [TURN_BITS-1:0]  w_cordic_z [2];
    logic                  w_finish_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_min <= ANGLE_MIN_RESET;
            r_angle_max <= ANGLE_MAX_RESET;
            r_near_r2   <= NEAR_R2_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_ANGLE_MIN: r_angle_min <= i_cfg_data[ANGLE_BITS-1:0];
                REG_ANGLE_MAX: r_angle_max <= i_cfg_data[ANGLE_BITS-1:0];
                REG_NEAR_R2:   r_near_r2   <= i_cfg_data[R2_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    hpdp_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (w_prep_ready),
        .i_parent_x    (i_parent_x),
        .i_parent_y    (i_parent_y),
        .i_child_x     (i_child_x),
        .i_child_y     (i_child_y),
        .i_parent_hits (i_parent_hits),
        .i_child_hits  (i_child_hits),
        .i_near_r2     (r_near_r2),
        .o_valid       (w_prep_valid),
        .i_ready       (w_cordic_ready),
        .o_side        (w_prep_side),
        .o_hit         (w_prep_hit)
    );

    hpdp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prep_valid),
        .o_ready (w_cordic_ready),
        .i_side  (w_prep_side),
        .i_hit   (w_prep_hit),
        .o_valid (w_cordic_valid),
        .i_ready (w_finish_ready),
        .o_side  (w_cordic_side),
        .o_z     (w_cordic_z)
    );

    hpdp_finish u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_cordic_valid),
        .o_ready      (w_finish_ready),
        .i_side       (w_cordic_side),
        .i_z          (w_cordic_z),
        .i_angle_min  (r_angle_min),
        .i_angle_max  (r_angle_max),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_verdict    (o_verdict),
        .o_angle_diff (o_angle_diff)
    );

    assign o_stall = !w_prep_ready;

    `HPDP_ASSERT_IMPLY(a_bad_len_zero, i_clk, i_rst_n, o_valid && (o_verdict == VERDICT_BAD_LEN), o_angle_diff == '0)
    `HPDP_ASSERT_IMPLY(a_pass_in_window, i_clk, i_rst_n, o_valid && (o_verdict == VERDICT_PASS), (o_angle_diff >= r_angle_min) && (o_angle_diff <= r_angle_max))
    `HPDP_ASSERT_IMPLY(a_no_stall_when_drained, i_clk, i_rst_n, !i_stall, !o_stall)
    `HPDP_ASSERT_IMPLY(a_no_stall_when_out_empty, i_clk, i_rst_n, !o_valid, !o_stall)

endmodule
